// ----- rtl/core/functor_intern_table_macros.svh -----
// ---------------------------------------------------------------------------
// functor_intern_table_macros
// Assertion macros for the functor interning table.
// ---------------------------------------------------------------------------
`ifndef FUNCTOR_INTERN_TABLE_MACROS_SVH
`define FUNCTOR_INTERN_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FIT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FIT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FIT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define FIT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/core/fit_pkg.sv -----
// ---------------------------------------------------------------------------
// fit_pkg
// Shared types and constants of the functor interning table.
// ---------------------------------------------------------------------------
package fit_pkg;

   localparam int CELLS       = 32;
   localparam int CELL_W      = 5;
   localparam int KEY_W       = 41;
   localparam int OUT_ID_W    = 10;
   localparam int CFG_W       = 11;
   localparam int MAX_ID_W    = 16;
   localparam logic [CFG_W-1:0] FIRST_FREE_RESET = 11'd22;

   // match result handed from cell to cell
   typedef struct packed {
      logic                hit;
      logic [MAX_ID_W-1:0] id;
   } chain_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

endpackage

// ----- rtl/core/fit_cell.sv -----
// ---------------------------------------------------------------------------
// fit_cell
// One bank of the key store with its comparator and chain stage.
// ---------------------------------------------------------------------------
module fit_cell #(
   parameter int CELL_IDX   = 0,
   parameter int BANK_DEPTH = 32,
   parameter int A_W        = 5,
   parameter int NF_W       = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [A_W-1:0]               rd_addr,
   input  logic                         wr_en,
   input  logic [fit_pkg::CELL_W-1:0]   wr_cell,
   input  logic [A_W-1:0]               wr_addr,
   input  logic [fit_pkg::KEY_W-1:0]    wr_key,
   input  logic [fit_pkg::KEY_W-1:0]    key,
   input  logic [NF_W-1:0]              lo_bound,
   input  logic [NF_W-1:0]              hi_bound,
   input  fit_pkg::chain_type           chain_in,
   output fit_pkg::chain_type           chain_out
);

   localparam int ID_W = A_W + fit_pkg::CELL_W;

   logic [fit_pkg::KEY_W-1:0] bank [BANK_DEPTH];

   logic [fit_pkg::KEY_W-1:0] rd_data_ff;
   logic [A_W-1:0]            rd_addr_ff;
   logic                      rd_vld_ff;
   fit_pkg::chain_type        chain_ff;
   fit_pkg::chain_type        chain_in_nxt;
   logic [ID_W-1:0]           slot_id;
   logic [NF_W-1:0]           slot_id_ext;
   logic                      hit;

   always_ff @(posedge clock) begin
      if (wr_en && (wr_cell == fit_pkg::CELL_W'(CELL_IDX))) begin
         bank[wr_addr] <= wr_key;
      end
      if (rd_en) begin
         rd_data_ff <= bank[rd_addr];
      end
      rd_addr_ff <= rd_addr;
   end

   assign slot_id     = {rd_addr_ff, fit_pkg::CELL_W'(CELL_IDX)};
   assign slot_id_ext = NF_W'(slot_id);
   // live slots are exactly lo_bound .. hi_bound-1
   assign hit = rd_vld_ff && (rd_data_ff == key) &&
                (slot_id_ext >= lo_bound) && (slot_id_ext < hi_bound);

   always_comb begin
      if (hit) begin
         chain_in_nxt.hit = 1'b1;
         chain_in_nxt.id  = fit_pkg::MAX_ID_W'(slot_id);
      end else begin
         chain_in_nxt = chain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         chain_ff  <= '0;
      end else begin
         rd_vld_ff <= rd_en;
         chain_ff  <= chain_in_nxt;
      end
   end

   assign chain_out = chain_ff;

endmodule

// ----- rtl/core/functor_intern_table.sv -----
// ---------------------------------------------------------------------------
// functor_intern_table
// Maps a functor key to a dense id, storing absent keys at the next free id.
// ---------------------------------------------------------------------------
// Keys are taken one at a time, as req_ready is high only in idle. Each key
// goes through bank scan, chain drain and decide, then back to idle; a held
// response stalls the decide.
// Reset: first_free_id = 22, table empty; a csr write also empties the table.
// Table contents need no clearing: live ids are first_free_id .. next_free-1.
module functor_intern_table #(
   parameter int CAPACITY = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_special_flag,
   input  logic [15:0]                  req_module_sym,
   input  logic [15:0]                  req_name_sym,
   input  logic [7:0]                   req_arg_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fit_pkg::OUT_ID_W-1:0] rsp_key_id,
   output logic                         rsp_found,
   output logic                         rsp_table_full,
   input  logic                         csr_we,
   input  logic [fit_pkg::CFG_W-1:0]    csr_wdata
);

`include "functor_intern_table_macros.svh"

   localparam int CELLS      = fit_pkg::CELLS;
   localparam int BANK_DEPTH = (CAPACITY + CELLS - 1) / CELLS;
   localparam int A_W        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int NF_W       = ($clog2(CAPACITY) + 1 > fit_pkg::CFG_W) ?
                               $clog2(CAPACITY) + 1 : fit_pkg::CFG_W;
   localparam int CNT_MAX    = (BANK_DEPTH - 1 > CELLS + 1) ? BANK_DEPTH - 1 : CELLS + 1;
   localparam int CNT_W      = $clog2(CNT_MAX + 1);

   fit_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [fit_pkg::KEY_W-1:0]     key_ff;
   logic [fit_pkg::CFG_W-1:0]     first_ff;
   logic [NF_W-1:0]               next_free_ff, next_free_in;
   logic                          hit_acc_ff, hit_acc_in;
   logic [fit_pkg::MAX_ID_W-1:0]  hit_id_ff, hit_id_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fit_pkg::OUT_ID_W-1:0]  rsp_id_ff;
   logic                          rsp_found_ff, rsp_full_ff;

   logic                          req_xfer;
   logic                          rd_en;
   logic                          do_commit;
   logic                          is_full;
   logic                          do_insert;
   logic [NF_W-1:0]               first_ext;
   fit_pkg::chain_type            chain [CELLS+1];

   assign req_ready = (state_ff == fit_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rd_en     = (state_ff == fit_pkg::ST_SCAN);
   assign first_ext = NF_W'(first_ff);
   assign is_full   = (next_free_ff >= NF_W'(CAPACITY));
   assign do_commit = (state_ff == fit_pkg::ST_DECIDE) && (!rsp_valid_ff || rsp_ready);
   assign do_insert = do_commit && !hit_acc_ff && !is_full;

   assign chain[CELLS] = '0;

   for (genvar c = 0; c < CELLS; c++) begin : g_cell
      fit_cell #(
         .CELL_IDX  (c),
         .BANK_DEPTH(BANK_DEPTH),
         .A_W       (A_W),
         .NF_W      (NF_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .rd_en    (rd_en),
         .rd_addr  (cnt_ff[A_W-1:0]),
         .wr_en    (do_insert),
         .wr_cell  (next_free_ff[fit_pkg::CELL_W-1:0]),
         .wr_addr  (next_free_ff[fit_pkg::CELL_W +: A_W]),
         .wr_key   (key_ff),
         .key      (key_ff),
         .lo_bound (first_ext),
         .hi_bound (next_free_ff),
         .chain_in (chain[c+1]),
         .chain_out(chain[c])
      );
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      hit_acc_in   = hit_acc_ff;
      hit_id_in    = hit_id_ff;
      rsp_valid_in = rsp_valid_ff;
      next_free_in = next_free_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == fit_pkg::ST_SCAN) || (state_ff == fit_pkg::ST_DRAIN)) begin
         if (chain[0].hit) begin
            hit_acc_in = 1'b1;
            hit_id_in  = chain[0].id;
         end
      end
      unique case (state_ff)
         fit_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in   = fit_pkg::ST_SCAN;
               cnt_in     = '0;
               hit_acc_in = 1'b0;
            end
         end
         fit_pkg::ST_SCAN: begin
            if (cnt_ff == CNT_W'(BANK_DEPTH - 1)) begin
               state_in = fit_pkg::ST_DRAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         fit_pkg::ST_DRAIN: begin
            // let the last compare walk down the whole chain
            if (cnt_ff == CNT_W'(CELLS + 1)) begin
               state_in = fit_pkg::ST_DECIDE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         fit_pkg::ST_DECIDE: begin
            if (do_commit) begin
               state_in     = fit_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (do_insert) begin
                  next_free_in = next_free_ff + NF_W'(1);
               end
            end
         end
         default: begin
            state_in = fit_pkg::ST_IDLE;
         end
      endcase
      if (csr_we) begin
         next_free_in = NF_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fit_pkg::ST_IDLE;
         cnt_ff       <= '0;
         hit_acc_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= fit_pkg::FIRST_FREE_RESET;
         next_free_ff <= NF_W'(fit_pkg::FIRST_FREE_RESET);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hit_acc_ff   <= hit_acc_in;
         rsp_valid_ff <= rsp_valid_in;
         next_free_ff <= next_free_in;
         if (csr_we) begin
            first_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_id_ff <= hit_id_in;
      if (req_xfer) begin
         key_ff <= {req_special_flag, req_module_sym, req_name_sym, req_arg_count};
      end
      if (do_commit) begin
         if (hit_acc_ff) begin
            rsp_id_ff    <= hit_id_ff[fit_pkg::OUT_ID_W-1:0];
            rsp_found_ff <= 1'b1;
            rsp_full_ff  <= 1'b0;
         end else if (is_full) begin
            rsp_id_ff    <= '0;
            rsp_found_ff <= 1'b0;
            rsp_full_ff  <= 1'b1;
         end else begin
            rsp_id_ff    <= next_free_ff[fit_pkg::OUT_ID_W-1:0];
            rsp_found_ff <= 1'b0;
            rsp_full_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_id     = rsp_id_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_table_full = rsp_full_ff;

   `FIT_ASSERT_IMPLY(a_found_not_full, clock, reset, rsp_valid_ff,
      !(rsp_found_ff && rsp_full_ff), "found and full together")
   `FIT_ASSERT_NEXT(a_insert_advances, clock, reset, do_insert && !csr_we,
      next_free_ff == $past(next_free_ff) + NF_W'(1), "next free id did not advance")
   `FIT_ASSERT_IMPLY(a_hit_in_range, clock, reset,
      (state_ff == fit_pkg::ST_DECIDE) && hit_acc_ff,
      (NF_W'(hit_id_ff) >= first_ext) && (NF_W'(hit_id_ff) < next_free_ff),
      "match outside live ids")
   `FIT_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1,
      (next_free_ff <= NF_W'(CAPACITY)) || (next_free_ff == first_ext),
      "next free id past capacity")

endmodule
